### sv/pfd_pkg.sv
package pfd_pkg;

  localparam int MODE_W = 2;
  localparam int ID_W   = 16;
  localparam int TIME_W = 32;
  localparam int CAP_W  = 7;
  localparam int CNT_W  = 7;

  localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FORWARD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COUNT   = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   source;
    logic [ID_W-1:0]   destination;
    logic [TIME_W-1:0] timestamp;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
  } item_t;

  typedef struct packed {
    logic              ok;
    logic [ID_W-1:0]   out_source;
    logic [ID_W-1:0]   out_destination;
    logic [TIME_W-1:0] out_timestamp;
    logic [CNT_W-1:0]  match_count;
  } result_t;

  // One stored packet, as held in the slot memory.
  typedef struct packed {
    logic [ID_W-1:0]   source;
    logic [ID_W-1:0]   destination;
    logic [TIME_W-1:0] timestamp;
  } packet_t;

  // Flags from the shared compare unit.
  typedef struct packed {
    logic dup;  // all three fields equal
    logic hit;  // destination equal and time inside the range
  } match_t;

endpackage

### sv/pfd_ram.sv
module pfd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/pfd_match.sv
module pfd_match (
  input  pfd_pkg::packet_t slot,
  input  pfd_pkg::item_t   probe,
  output pfd_pkg::match_t  flags
);

  import pfd_pkg::*;

  logic dst_eq;

  assign dst_eq    = (slot.destination == probe.destination);
  assign flags.dup = dst_eq && (slot.source == probe.source) &&
                     (slot.timestamp == probe.timestamp);
  // A reversed range fails one of the two bounds, so it never hits.
  assign flags.hit = dst_eq && (slot.timestamp >= probe.start_time) &&
                     (slot.timestamp <= probe.end_time);

endmodule

### sv/packet_fifo_dedup_range_count.sv
// Bounded FIFO packet buffer with a duplicate filter and a range counter.
//
// Command channel: present an item word on item with start high; it is taken
// at a clock edge where start is high and busy is low. busy stays high while
// the item is worked on. Modes: add appends a packet unless an identical one
// is held (evicting the oldest when occupancy reaches the limit), forward pops
// the oldest packet, count returns how many held packets match a destination
// and an inclusive time range. An unused mode gives an all-zero result.
// Result channel: one result word per item on result, shown for exactly one
// cycle with result_valid high. The receiver cannot stall it; take it then.
// A count or add scans the held slots through the single read port of the slot
// memory, one slot per cycle, into the shared compare unit; add stops early
// when it finds a duplicate. forward reads only the oldest slot, and an empty
// count, an empty forward or an unused mode answers without a scan. busy drops
// in the cycle the result is shown, so a new item may be taken then.
// Configuration: capacity_limit is written on cfg_valid && cfg_ready; the user
// must write it only while idle, as the block itself does not enforce this.
// Reset (rst, synchronous) empties the buffer and sets the limit to 64; slot
// contents are not cleared and need no clearing pass.
module packet_fifo_dedup_range_count #(
  parameter int DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  pfd_pkg::item_t          item,
  output logic                    result_valid,
  output pfd_pkg::result_t        result,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [pfd_pkg::CAP_W-1:0] cfg_data
);

  import pfd_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;
  localparam int LIM_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FWD   = 4'b0100,
    S_WRITE = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [CAP_W-1:0]  capacity_limit;
  logic [IDX_W-1:0]  head, head_next;
  logic [OCC_W-1:0]  occupancy, occupancy_next;
  item_t             item_q, item_q_next;
  logic [OCC_W-1:0]  lim, lim_next;
  logic [IDX_W-1:0]  rd_ptr, rd_ptr_next;
  logic [OCC_W-1:0]  issue_cnt, issue_cnt_next;
  logic              rd_valid, rd_valid_next;
  logic              rd_last, rd_last_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  result_t           result_next;
  logic              result_valid_next;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  logic [$bits(packet_t)-1:0] ram_rdata;
  packet_t           rd_pkt, wr_pkt;
  match_t            flags;

  logic [LIM_W-1:0]  cap_ext;
  logic [OCC_W-1:0]  lim_eff;
  logic [SUM_W-1:0]  tail_sum;
  logic [IDX_W-1:0]  tail;

  // Advance a slot index around the circular store.
  function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] idx);
    inc_idx = (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Clamp the limit: zero acts as one, anything above DEPTH acts as DEPTH.
  assign cap_ext = LIM_W'(capacity_limit);
  always_comb begin
    if (capacity_limit == '0) begin
      lim_eff = OCC_W'(1);
    end else if (cap_ext > LIM_W'(DEPTH)) begin
      lim_eff = OCC_W'(DEPTH);
    end else begin
      lim_eff = OCC_W'(cap_ext);
    end
  end

  // Slot after the newest packet. With an eviction the head moves by one and
  // the occupancy drops by one, so the write slot is the same either way.
  assign tail_sum = SUM_W'(head) + SUM_W'(occupancy);
  assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                : IDX_W'(tail_sum);

  assign rd_pkt             = packet_t'(ram_rdata);
  assign wr_pkt.source      = item_q.source;
  assign wr_pkt.destination = item_q.destination;
  assign wr_pkt.timestamp   = item_q.timestamp;

  pfd_ram #(
    .WIDTH ($bits(packet_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (wr_pkt),
    .rdata (ram_rdata)
  );

  // Shared compare unit: one held slot per cycle against the latched item.
  pfd_match u_match (
    .slot  (rd_pkt),
    .probe (item_q),
    .flags (flags)
  );

  always_comb begin
    state_next        = state;
    head_next         = head;
    occupancy_next    = occupancy;
    item_q_next       = item_q;
    lim_next          = lim;
    rd_ptr_next       = rd_ptr;
    issue_cnt_next    = issue_cnt;
    rd_valid_next     = 1'b0;
    rd_last_next      = rd_last;
    cnt_next          = cnt;
    result_next       = '0;
    result_valid_next = 1'b0;
    ram_we            = 1'b0;
    ram_addr          = head;

    unique case (state)
      S_IDLE: begin
        // The oldest slot is read here on every start, so the scan and the
        // forward path both begin with the head already on its way.
        if (start) begin
          item_q_next    = item;
          lim_next       = lim_eff;
          cnt_next       = '0;
          rd_ptr_next    = inc_idx(head);
          issue_cnt_next = OCC_W'(1);
          rd_last_next   = (occupancy == OCC_W'(1));
          unique case (item.mode)
            MODE_ADD: begin
              rd_valid_next = (occupancy != '0);
              state_next    = (occupancy == '0) ? S_WRITE : S_SCAN;
            end
            MODE_FORWARD: begin
              if (occupancy == '0) begin
                result_valid_next = 1'b1;
              end else begin
                state_next = S_FWD;
              end
            end
            MODE_COUNT: begin
              if (occupancy == '0) begin
                result_valid_next = 1'b1;
              end else begin
                rd_valid_next = 1'b1;
                state_next    = S_SCAN;
              end
            end
            default: begin
              // Unused mode: no state change, zero result.
              result_valid_next = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        ram_addr = rd_ptr;
        // Issue the next read while slots remain.
        if (issue_cnt < occupancy) begin
          rd_valid_next  = 1'b1;
          rd_last_next   = (issue_cnt == occupancy - OCC_W'(1));
          rd_ptr_next    = inc_idx(rd_ptr);
          issue_cnt_next = issue_cnt + OCC_W'(1);
        end
        // Retire the slot whose data arrived this cycle.
        if (rd_valid) begin
          if (item_q.mode == MODE_ADD) begin
            if (flags.dup) begin
              // Duplicate: drop the packet, report ok low.
              result_valid_next = 1'b1;
              rd_valid_next     = 1'b0;
              state_next        = S_IDLE;
            end else if (rd_last) begin
              state_next = S_WRITE;
            end
          end else begin
            cnt_next = cnt + CNT_W'(flags.hit);
            if (rd_last) begin
              result_next.match_count = cnt + CNT_W'(flags.hit);
              result_valid_next       = 1'b1;
              state_next              = S_IDLE;
            end
          end
        end
      end

      S_FWD: begin
        result_next.ok              = 1'b1;
        result_next.out_source      = rd_pkt.source;
        result_next.out_destination = rd_pkt.destination;
        result_next.out_timestamp   = rd_pkt.timestamp;
        result_valid_next           = 1'b1;
        head_next                   = inc_idx(head);
        occupancy_next              = occupancy - OCC_W'(1);
        state_next                  = S_IDLE;
      end

      S_WRITE: begin
        ram_we   = 1'b1;
        ram_addr = tail;
        if (occupancy >= lim) begin
          // Evict the oldest; occupancy stays put.
          head_next = inc_idx(head);
        end else begin
          occupancy_next = occupancy + OCC_W'(1);
        end
        result_next.ok    = 1'b1;
        result_valid_next = 1'b1;
        state_next        = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      head           <= '0;
      occupancy      <= '0;
      capacity_limit <= CAP_RESET;
      rd_valid       <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      state        <= state_next;
      head         <= head_next;
      occupancy    <= occupancy_next;
      rd_valid     <= rd_valid_next;
      result_valid <= result_valid_next;
      if (cfg_valid && cfg_ready) begin
        capacity_limit <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_q    <= item_q_next;
    lim       <= lim_next;
    rd_ptr    <= rd_ptr_next;
    issue_cnt <= issue_cnt_next;
    rd_last   <= rd_last_next;
    cnt       <= cnt_next;
    result    <= result_next;
  end

  // A result is only shown once the sequencer is back to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result shown while busy");

  // Every accepted item either starts work or answers at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || result_valid))
    else $error("accepted item neither started nor answered");

  // Occupancy never exceeds the store.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_W'(DEPTH))
    else $error("occupancy above depth");

  // Occupancy and head move only together with a delivered result.
  a_state_with_result: assert property (@(posedge clk) disable iff (rst)
    (!$stable(occupancy) || !$stable(head)) |-> result_valid)
    else $error("buffer state changed without a result");

endmodule

### verif/packet_buffer_checker.sv
module packet_buffer_checker #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  pfd_pkg::item_t            item,
  input  logic                      result_valid,
  input  pfd_pkg::result_t          result,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [pfd_pkg::CAP_W-1:0] cfg_data,
  output int                        faults,
  output int                        waiting
);

  import pfd_pkg::*;

  // Shadow of the packet store: circular slots, oldest at head.
  packet_t          slots [DEPTH];
  int unsigned      head;
  int unsigned      held;
  logic [CAP_W-1:0] limit;

  result_t awaited_words [$];
  result_t want;

  // Apply one command word to the shadow store and return the word it yields.
  function automatic result_t step_buffer(input item_t cmd);
    result_t     r;
    packet_t     p;
    int unsigned cap;
    int unsigned hits;
    int unsigned k;
    logic        dup;
    r = '0;
    hits = 0;
    dup = 1'b0;
    case (cmd.mode)
      MODE_ADD: begin
        cap = (limit == 0) ? 1 : ((limit > DEPTH) ? DEPTH : limit);
        for (k = 0; k < held; k++) begin
          p = slots[(head + k) % DEPTH];
          if (p.source == cmd.source && p.destination == cmd.destination &&
              p.timestamp == cmd.timestamp)
            dup = 1'b1;
        end
        if (!dup) begin
          // Evict only the single oldest packet, even above the limit.
          if (held >= cap) begin
            head = (head + 1) % DEPTH;
            held--;
          end
          p.source = cmd.source;
          p.destination = cmd.destination;
          p.timestamp = cmd.timestamp;
          slots[(head + held) % DEPTH] = p;
          held++;
          r.ok = 1'b1;
        end
      end
      MODE_FORWARD: begin
        if (held != 0) begin
          p = slots[head];
          r.ok = 1'b1;
          r.out_source = p.source;
          r.out_destination = p.destination;
          r.out_timestamp = p.timestamp;
          head = (head + 1) % DEPTH;
          held--;
        end
      end
      MODE_COUNT: begin
        for (k = 0; k < held; k++) begin
          p = slots[(head + k) % DEPTH];
          if (p.destination == cmd.destination && p.timestamp >= cmd.start_time &&
              p.timestamp <= cmd.end_time)
            hits++;
        end
        r.match_count = hits[CNT_W-1:0];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Compare the result word before queueing a new prediction: a word taken
  // at the same edge belongs to a later command.
  always @(posedge clk) begin
    if (rst) begin
      head = 0;
      held = 0;
      limit = CAP_RESET;
      awaited_words.delete();
      faults = 0;
      waiting = 0;
    end else begin
      if (cfg_valid && cfg_ready)
        limit = cfg_data;
      if (result_valid) begin
        if (awaited_words.size() == 0) begin
          if (faults < 10)
            $display("%0t: unexpected result word %h", $time, result);
          faults++;
        end else begin
          want = awaited_words.pop_front();
          if (result.ok !== want.ok || result.out_source !== want.out_source ||
              result.out_destination !== want.out_destination ||
              result.out_timestamp !== want.out_timestamp ||
              result.match_count !== want.match_count) begin
            if (faults < 10)
              $display("%0t: expected ok=%b src=%h dst=%h ts=%h cnt=%0d, got ok=%b src=%h dst=%h ts=%h cnt=%0d",
                       $time, want.ok, want.out_source, want.out_destination,
                       want.out_timestamp, want.match_count, result.ok,
                       result.out_source, result.out_destination,
                       result.out_timestamp, result.match_count);
            faults++;
          end
        end
      end
      if (start && !busy)
        awaited_words.push_back(step_buffer(item));
      waiting = awaited_words.size();
    end
  end

endmodule

### verif/packet_fifo_dedup_range_count_test.sv
module packet_fifo_dedup_range_count_test;

  import pfd_pkg::*;

  // The block leaves mode three unused; it must answer with an all-zero word.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  // Phase entry that asks for a limit drawn at random.
  localparam int LIMIT_RANDOM = 255;
  localparam int PHASES = 10;

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  item_t            item;
  logic             result_valid;
  result_t          result;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  int faults;
  int waiting;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  packet_fifo_dedup_range_count #(.DEPTH(64)) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // Watch both channels, predict each result word and compare it.
  packet_buffer_checker #(.DEPTH(64)) buffer_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .faults       (faults),
    .waiting      (waiting)
  );

  // Build one command word from explicit fields.
  function automatic item_t packet_cmd(input logic [MODE_W-1:0] mode,
                                       input logic [ID_W-1:0] src,
                                       input logic [ID_W-1:0] dst,
                                       input logic [TIME_W-1:0] ts,
                                       input logic [TIME_W-1:0] t0,
                                       input logic [TIME_W-1:0] t1);
    item_t c;
    c.mode = mode;
    c.source = src;
    c.destination = dst;
    c.timestamp = ts;
    c.start_time = t0;
    c.end_time = t1;
    return c;
  endfunction

  // Draw identifiers mostly from a small pool so that duplicates and
  // destination matches are common; the rest are raw random values.
  function automatic logic [ID_W-1:0] pick_id();
    logic [ID_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 4))
      0: v = 16'h0000;
      1: v = 16'h0001;
      2: v = 16'h8000;
      3: v = 16'hFFFF;
      default: begin
      end
    endcase
    return v;
  endfunction

  // Same idea for timestamps, with both ends of the unsigned range in the pool.
  function automatic logic [TIME_W-1:0] pick_time();
    logic [TIME_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v = 32'h0000_0000;
      1: v = 32'h0000_0001;
      2: v = 32'd100;
      3: v = 32'd101;
      4: v = 32'h7FFF_FFFF;
      5: v = 32'h8000_0000;
      6: v = 32'hFFFF_FFFE;
      7: v = 32'hFFFF_FFFF;
      default: begin
      end
    endcase
    return v;
  endfunction

  // Random command word. add_pct sets the share of adds; forwards take half
  // of the rest, counts the other half, and a few words use the unused mode.
  function automatic item_t random_command(input int unsigned add_pct);
    item_t             c;
    int unsigned       roll;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    c.source = pick_id();
    c.destination = pick_id();
    c.timestamp = pick_time();
    c.start_time = $urandom;
    c.end_time = $urandom;
    roll = $urandom_range(0, 99);
    if (roll >= 97) begin
      c.mode = MODE_UNUSED;
    end else if (roll < add_pct) begin
      c.mode = MODE_ADD;
    end else if (roll < add_pct + (97 - add_pct) / 2) begin
      c.mode = MODE_FORWARD;
    end else begin
      c.mode = MODE_COUNT;
      a = pick_time();
      b = pick_time();
      roll = $urandom_range(0, 99);
      // Mix full-range, ordered, reversed and raw random windows.
      if (roll < 30) begin
        c.start_time = '0;
        c.end_time = '1;
      end else if (roll < 70) begin
        c.start_time = (a <= b) ? a : b;
        c.end_time = (a <= b) ? b : a;
      end else if (roll < 85) begin
        c.start_time = (a <= b) ? b : a;
        c.end_time = (a <= b) ? a : b;
      end
    end
    return c;
  endfunction

  // Present a word and hold it until the block takes it (start && !busy).
  task automatic issue(input item_t w);
    @(negedge clk);
    start <= 1'b1;
    item <= w;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Drop start for an idle gap set by n.
  task automatic hold_off(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Drop start and wait until every predicted word has come back, with a
  // bound so a lost word cannot hang the run here.
  task automatic settle();
    int unsigned guard;
    guard = 0;
    @(negedge clk);
    start <= 1'b0;
    while (waiting != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
  endtask

  // Write capacity_limit once the block is idle.
  task automatic write_limit(input logic [CAP_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Directed words at the reset limit: empty buffer, field extremes,
  // near-duplicates that differ in one field, range edges, reversed range
  // and the unused mode.
  task automatic run_directed();
    issue(packet_cmd(MODE_FORWARD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0));
    issue(packet_cmd(MODE_COUNT, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'hFFFF_FFFF));
    issue(packet_cmd(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF));
    issue(packet_cmd(MODE_ADD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0));
    issue(packet_cmd(MODE_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0));
    // Identical packet: reject.
    issue(packet_cmd(MODE_ADD, 16'h0000, 16'h0000, 32'h0, 32'hFFFF_FFFF, 32'h0));
    // Three words differ in one field: accept; then a repeat: reject.
    issue(packet_cmd(MODE_ADD, 16'h0000, 16'h0000, 32'h1, 32'h0, 32'h0));
    issue(packet_cmd(MODE_ADD, 16'h0001, 16'h0000, 32'h0, 32'h0, 32'h0));
    issue(packet_cmd(MODE_ADD, 16'h0000, 16'h0001, 32'h0, 32'h0, 32'h0));
    issue(packet_cmd(MODE_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0));
    issue(packet_cmd(MODE_COUNT, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'hFFFF_FFFF));
    // Reversed window counts zero.
    issue(packet_cmd(MODE_COUNT, 16'h0000, 16'h0000, 32'h0, 32'h1, 32'h0));
    issue(packet_cmd(MODE_COUNT, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0));
    issue(packet_cmd(MODE_COUNT, 16'hFFFF, 16'hFFFF, 32'h0, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF));
    issue(packet_cmd(MODE_COUNT, 16'h0000, 16'h0000, 32'h0, 32'h1, 32'h1));
    issue(packet_cmd(MODE_UNUSED, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0));
    issue(packet_cmd(MODE_COUNT, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'hFFFF_FFFF));
    issue(packet_cmd(MODE_FORWARD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0));
    issue(packet_cmd(MODE_FORWARD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0));
    // The first packet is gone now, so the same packet goes in again.
    issue(packet_cmd(MODE_ADD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0));
  endtask

  initial begin
    int unsigned ph;
    int unsigned n;
    int unsigned lim;
    int unsigned items;
    int unsigned add_pct;
    int unsigned idle_pct;

    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();

    // Phases: each sets a limit (extremes, zero, above the store depth, a
    // drop below the current fill), a command mix and an idle rate. The
    // last phase runs back to back.
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin lim = 64;           items = 300; add_pct = 70; idle_pct = 20; end
        1: begin lim = 5;            items = 200; add_pct = 50; idle_pct = 30; end
        2: begin lim = 1;            items = 150; add_pct = 50; idle_pct = 0;  end
        3: begin lim = 0;            items = 150; add_pct = 45; idle_pct = 25; end
        4: begin lim = 127;          items = 250; add_pct = 65; idle_pct = 15; end
        5: begin lim = 100;          items = 200; add_pct = 35; idle_pct = 30; end
        6: begin lim = 2;            items = 150; add_pct = 50; idle_pct = 20; end
        7: begin lim = LIMIT_RANDOM; items = 200; add_pct = 55; idle_pct = 10; end
        8: begin lim = LIMIT_RANDOM; items = 200; add_pct = 30; idle_pct = 25; end
        default: begin lim = 64;     items = 150; add_pct = 45; idle_pct = 0;  end
      endcase
      if (lim == LIMIT_RANDOM)
        lim = $urandom_range(1, 127);
      // Keep the reset limit for the first phase.
      if (ph != 0)
        write_limit(lim[CAP_W-1:0]);
      for (n = 0; n < items; n++) begin
        if ($urandom_range(0, 99) < idle_pct)
          hold_off($urandom_range(1, 9));
        issue(random_command(add_pct));
      end
    end

    settle();
    // Give a stray late word time to show up.
    repeat (80) @(negedge clk);
    if (faults == 0 && waiting == 0)
      $display("packet_fifo_dedup_range_count_test OK");
    else
      $display("packet_fifo_dedup_range_count_test NOT OK");
    $finish;
  end

  // Stop a hung run.
  initial begin
    #12000000;
    $display("packet_fifo_dedup_range_count_test NOT OK");
    $finish;
  end

endmodule
